>>> src/interval_occupancy_peak_tracker_core_assert.svh
// Assertion macros shared by the RTL modules.
// Each macro compiles away when SYNTHESIS is defined.
`ifndef INTERVAL_OCCUPANCY_PEAK_TRACKER_CORE_ASSERT_SVH
`define INTERVAL_OCCUPANCY_PEAK_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check an expression at every clock edge outside reset.
`define IOPT_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("iopt assertion failed");

// Check that the antecedent in one cycle implies the consequent in the next.
`define IOPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("iopt assertion failed");

`else

`define IOPT_ASSERT(lbl, clk, rstn, expr)
`define IOPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> src/iopt_pkg.sv
package iopt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int TIME_W       = 30;
    localparam int COUNT_W      = 7;

    // stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_W = ((2 * TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * COUNT_W + 1 + 7) / 8) * 8;
    localparam int IN_PAD_W  = S_TDATA_W - 2 * TIME_W;
    localparam int OUT_PAD_W = M_TDATA_W - 2 * COUNT_W - 1;

    typedef struct packed {
        logic load;     // capture a new item and restart the scan
        logic scan;     // walk the held departures, compacting the survivors
        logic commit;   // insert the departure and load the result
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } status_t;

endpackage

>>> src/iopt_dp.sv
module iopt_dp #(
    parameter int CAPACITY = iopt_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iopt_pkg::cmd_t                cmd,
    output iopt_pkg::status_t             status,
    input  logic [iopt_pkg::TIME_W-1:0]   arrival_time,
    input  logic [iopt_pkg::TIME_W-1:0]   departure_time,
    output logic [iopt_pkg::COUNT_W-1:0]  occupied_count,
    output logic [iopt_pkg::COUNT_W-1:0]  peak_count,
    output logic                          overflow
);
    import iopt_pkg::*;

`include "interval_occupancy_peak_tracker_core_assert.svh"

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [TIME_W-1:0] mem [CAPACITY];

    logic [TIME_W-1:0]  arrival_reg;
    logic [TIME_W-1:0]  departure_reg;
    logic [TIME_W-1:0]  rd_data_reg;
    logic [CNT_W-1:0]   live_reg;
    logic [CNT_W-1:0]   peak_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [CNT_W-1:0]   keep_reg;
    logic               pend_reg;
    logic [COUNT_W-1:0] occ_out_reg;
    logic [COUNT_W-1:0] peak_out_reg;
    logic               ovf_out_reg;

    logic              rd_en;
    logic              keep_hit;
    logic              full;
    logic              wr_en;
    logic [TIME_W-1:0] wr_data;
    logic [CNT_W-1:0]  live_next;
    logic [CNT_W-1:0]  peak_next;

    // keep_reg trails rd_idx_reg, so a compaction write never lands on
    // an entry still to be read
    assign rd_en    = cmd.scan && (rd_idx_reg != live_reg);
    assign keep_hit = cmd.scan && pend_reg && (rd_data_reg >= arrival_reg);
    assign full     = (keep_reg == CNT_W'(CAPACITY));
    assign wr_en    = keep_hit || (cmd.commit && !full);
    assign wr_data  = cmd.commit ? departure_reg : rd_data_reg;

    always_comb
    begin
        live_next = full ? keep_reg : keep_reg + 1'b1;
        peak_next = (live_next > peak_reg) ? live_next : peak_reg;
    end

    assign status.scan_done = !pend_reg && (rd_idx_reg == live_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[keep_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg   <= '0;
            peak_reg   <= '0;
            rd_idx_reg <= '0;
            keep_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            rd_idx_reg <= '0;
            keep_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else if (cmd.scan)
        begin
            pend_reg <= rd_en;
            if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (keep_hit)
            begin
                keep_reg <= keep_reg + 1'b1;
            end
        end
        else if (cmd.commit)
        begin
            live_reg <= live_next;
            peak_reg <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arrival_reg   <= arrival_time;
            departure_reg <= departure_time;
        end
        if (cmd.commit)
        begin
            occ_out_reg  <= COUNT_W'(live_next);
            peak_out_reg <= COUNT_W'(peak_next);
            ovf_out_reg  <= full;
        end
    end

    assign occupied_count = occ_out_reg;
    assign peak_count     = peak_out_reg;
    assign overflow       = ovf_out_reg;

    `IOPT_ASSERT(a_live_bound, clk, rst_n, live_reg <= CNT_W'(CAPACITY))
    `IOPT_ASSERT(a_keep_trails, clk, rst_n, keep_reg <= rd_idx_reg)
    `IOPT_ASSERT(a_peak_covers, clk, rst_n, peak_reg >= live_reg)

endmodule

>>> src/iopt_ctrl.sv
module iopt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output iopt_pkg::cmd_t    cmd,
    input  iopt_pkg::status_t status
);
    import iopt_pkg::*;

`include "interval_occupancy_peak_tracker_core_assert.svh"

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        COMMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready   = (state_reg == IDLE);
    assign cmd.load   = in_valid && in_ready;
    assign cmd.scan   = (state_reg == SCAN);
    // the result register must be free (or being drained) before reloading
    assign cmd.commit = (state_reg == COMMIT) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    if (status.scan_done)
                    begin
                        state_reg <= COMMIT;
                    end
                end
                COMMIT:
                begin
                    if (cmd.commit)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    `IOPT_ASSERT(a_cmd_excl, clk, rst_n, $onehot0({cmd.load, cmd.scan, cmd.commit}))
    `IOPT_ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_valid_reg && in_ready)
    `IOPT_ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load, !in_ready && !cmd.commit)

endmodule

>>> src/interval_occupancy_peak_tracker_core.sv
// Occupancy tracker for reservations: each input item carries an arrival and
// a departure time. Held departures strictly below the arrival are released,
// then the departure is held. One result item per input item gives the live
// occupancy, the peak occupancy since reset, and an overflow flag when the
// store was full and the item was dropped.
// Channels: s_axis (input items), m_axis (result items), both valid/ready.
// With held departures, the scan streams them through the memory read port
// (one entry per cycle, survivors written back compacted), then makes the
// last compare and finishes; the insert step then inserts the departure and
// loads the result register. The next item is accepted in the cycle after
// the result is loaded, while that result may still wait to be taken.
// Reset clears the counts and the control state; the memory needs no
// clearing, since only entries below the live count are ever read.
// A stalled receiver holds the result; the next item's scan proceeds and
// waits only at the insert step until the result register is free.
module interval_occupancy_peak_tracker_core #(
    parameter int CAPACITY = iopt_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // arrival_time[29:0], departure_time[59:30], zero pad
    input  logic [iopt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // occupied_count[6:0], peak_count[13:7], overflow[14], zero pad
    output logic [iopt_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import iopt_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [COUNT_W-1:0] occupied_count;
    logic [COUNT_W-1:0] peak_count;
    logic               overflow;

    iopt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    iopt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .arrival_time   (s_axis_tdata[TIME_W-1:0]),
        .departure_time (s_axis_tdata[2*TIME_W-1:TIME_W]),
        .occupied_count (occupied_count),
        .peak_count     (peak_count),
        .overflow       (overflow)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, overflow, peak_count, occupied_count};

endmodule
